[rtl/assert_macros.svh]
// shared assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/pbi_pkg.sv]
package pbi_pkg;

	localparam logic [31:0] GRAVITY   = 32'h0000_0333;
	localparam logic [48:0] Q12_ROUND = 49'h800;

	localparam logic signed [15:0] VIS_MIN   = -16'sd16;
	localparam logic signed [15:0] VIS_MAX_X = 16'sd272;
	localparam logic signed [15:0] VIS_MAX_Y = 16'sd208;

	localparam logic [31:0] RST_BOUND_LEFT   = 32'd262144;
	localparam logic [31:0] RST_BOUND_TOP    = 32'd163840;
	localparam logic [31:0] RST_BOUND_RIGHT  = 32'd786432;
	localparam logic [31:0] RST_BOUND_BOTTOM = 32'd737280;
	localparam logic [15:0] RST_DAMPING_GAIN = 16'h0ccd;
	localparam logic [15:0] RST_PULL_GAIN    = 16'h0b33;

	typedef enum logic [2:0] {
		CFG_BOUND_LEFT   = 3'd0,
		CFG_BOUND_TOP    = 3'd1,
		CFG_BOUND_RIGHT  = 3'd2,
		CFG_BOUND_BOTTOM = 3'd3,
		CFG_DAMPING_GAIN = 3'd4,
		CFG_PULL_GAIN    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] bound_left;
		logic [31:0] bound_top;
		logic [31:0] bound_right;
		logic [31:0] bound_bottom;
		logic [15:0] damping_gain;
		logic [15:0] pull_gain;
	} cfg_t;

	// stage load enables for the axis pipelines
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
	} ctrl_t;

	// rounded q12 multiply: (p + 0x800) >>> 12, low 32 bits
	function automatic logic [31:0] qround(input logic signed [48:0] p);
		logic [48:0] s;
		s = p + Q12_ROUND;
		return s[43:12];
	endfunction

endpackage

[rtl/pbi_in_if.sv]
interface pbi_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] vel_x;
	logic [31:0] vel_y;
	logic [19:0] radius;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, radius, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, radius, output ready);
endinterface

[rtl/pbi_out_if.sv]
interface pbi_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] next_pos_x;
	logic [31:0] next_pos_y;
	logic [31:0] next_vel_x;
	logic [31:0] next_vel_y;
	logic [15:0] pixel_x;
	logic [15:0] pixel_y;
	logic        visible;

	modport source (output valid, next_pos_x, next_pos_y, next_vel_x, next_vel_y,
		pixel_x, pixel_y, visible, input ready);
	modport sink (input valid, next_pos_x, next_pos_y, next_vel_x, next_vel_y,
		pixel_x, pixel_y, visible, output ready);
endinterface

[rtl/pbi_cfg_regs.sv]
module pbi_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [31:0]   cfg_data,
	output pbi_pkg::cfg_t cfg
);
	import pbi_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bound_left   <= RST_BOUND_LEFT;
			cfg_q.bound_top    <= RST_BOUND_TOP;
			cfg_q.bound_right  <= RST_BOUND_RIGHT;
			cfg_q.bound_bottom <= RST_BOUND_BOTTOM;
			cfg_q.damping_gain <= RST_DAMPING_GAIN;
			cfg_q.pull_gain    <= RST_PULL_GAIN;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_BOUND_LEFT:   cfg_q.bound_left   <= cfg_data;
				CFG_BOUND_TOP:    cfg_q.bound_top    <= cfg_data;
				CFG_BOUND_RIGHT:  cfg_q.bound_right  <= cfg_data;
				CFG_BOUND_BOTTOM: cfg_q.bound_bottom <= cfg_data;
				CFG_DAMPING_GAIN: cfg_q.damping_gain <= cfg_data[15:0];
				CFG_PULL_GAIN:    cfg_q.pull_gain    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

[rtl/pbi_axis.sv]
module pbi_axis (
	input  logic           clk,
	input  pbi_pkg::ctrl_t ctrl,
	input  logic [15:0]    damping_gain,
	input  logic [15:0]    pull_gain,
	input  logic [31:0]    pos_s1,
	input  logic [31:0]    vel_s1,
	input  logic [31:0]    lo_s1,
	input  logic [31:0]    hi_s1,
	output logic [31:0]    pos_s5,
	output logic [31:0]    vel_s5
);
	import pbi_pkg::*;

	logic signed [16:0] neg_damp;
	logic signed [16:0] pull;

	logic              hit_s2, out_s2;
	logic [31:0]       pos_s2, vel_s2, hi_s2;
	logic signed [48:0] vprod_s2, pprod_s2;

	logic [31:0]       pos_s3, vel_s3, hi_s3;

	logic              hit_s4, out_s4;
	logic [31:0]       pos_s4, vel_s4;
	logic signed [48:0] vprod_s4, pprod_s4;

	assign neg_damp = 17'sd0 - $signed({1'b0, damping_gain});
	assign pull     = $signed({1'b0, pull_gain});

	// low edge: compare and both products
	always_ff @(posedge clk) begin
		if (ctrl.ld_s2) begin
			hit_s2   <= $signed(pos_s1) < $signed(lo_s1);
			out_s2   <= vel_s1[31];
			vprod_s2 <= $signed(vel_s1) * neg_damp;
			pprod_s2 <= pull * $signed(lo_s1 - pos_s1);
			pos_s2   <= pos_s1;
			vel_s2   <= vel_s1;
			hi_s2    <= hi_s1;
		end
	end

	// low edge: round and apply
	always_ff @(posedge clk) begin
		if (ctrl.ld_s3) begin
			pos_s3 <= hit_s2 ? pos_s2 + qround(pprod_s2) : pos_s2;
			vel_s3 <= (hit_s2 && out_s2) ? qround(vprod_s2) : vel_s2;
			hi_s3  <= hi_s2;
		end
	end

	// high edge on the corrected position
	always_ff @(posedge clk) begin
		if (ctrl.ld_s4) begin
			hit_s4   <= $signed(pos_s3) > $signed(hi_s3);
			out_s4   <= !vel_s3[31] && (vel_s3 != '0);
			vprod_s4 <= $signed(vel_s3) * neg_damp;
			pprod_s4 <= pull * $signed(hi_s3 - pos_s3);
			pos_s4   <= pos_s3;
			vel_s4   <= vel_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s5) begin
			pos_s5 <= hit_s4 ? pos_s4 + qround(pprod_s4) : pos_s4;
			vel_s5 <= (hit_s4 && out_s4) ? qround(vprod_s4) : vel_s4;
		end
	end
endmodule

[rtl/particle_bounds_integrate.sv]
// channel    dir   payload                                           transfer when
// particle   in    pos_x pos_y vel_x vel_y radius                    valid && ready
// result     out   next_pos_x/y next_vel_x/y pixel_x/y visible       valid && ready
// cfg        in    cfg_idx cfg_data                                  cfg_we
//
// one particle per cycle sustained while result.ready stays high
// stages: s1 offsets and gravity, s2/s3 left/top edge, s4/s5 right/bottom edge, s6 output
// each edge takes a 32x17 multiply stage then a round-and-add stage
// arst_n clears the stage valid bits and loads the register reset values
// a stall at the result holds each full stage; empty stages keep filling behind it

`include "assert_macros.svh"

module particle_bounds_integrate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	pbi_in_if.sink      particle,
	pbi_out_if.source   result
);
	import pbi_pkg::*;

	cfg_t  cfg;
	ctrl_t ctrl;

	// stage valid bits and per-stage ready chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	// stage 1 payload
	logic [31:0] pos_x_s1, pos_y_s1, vel_x_s1, vel_y_s1;
	logic [31:0] lo_x_s1, hi_x_s1, lo_y_s1, hi_y_s1;

	// axis outputs after both edges
	logic [31:0] pos_x_s5, pos_y_s5, vel_x_s5, vel_y_s5;

	// final integration
	logic [31:0] sum_x, sum_y;
	logic signed [15:0] pix_x, pix_y;

	// output stage
	logic [31:0] nx_s6, ny_s6, nvx_s6, nvy_s6;
	logic [15:0] px_s6, py_s6;
	logic        vis_s6;

	pbi_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// a stage takes new data when empty or when the stage after it moves on
	assign rdy_s6 = !v_s6 || result.ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign particle.ready = rdy_s1;

	assign ctrl.ld_s2 = rdy_s2;
	assign ctrl.ld_s3 = rdy_s3;
	assign ctrl.ld_s4 = rdy_s4;
	assign ctrl.ld_s5 = rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= particle.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// rectangle shrunk by the radius, gravity added to vertical velocity
	always_ff @(posedge clk) begin
		if (rdy_s1 && particle.valid) begin
			pos_x_s1 <= particle.pos_x;
			pos_y_s1 <= particle.pos_y;
			vel_x_s1 <= particle.vel_x;
			vel_y_s1 <= particle.vel_y + GRAVITY;
			lo_x_s1  <= cfg.bound_left   + {12'd0, particle.radius};
			hi_x_s1  <= cfg.bound_right  - {12'd0, particle.radius};
			lo_y_s1  <= cfg.bound_top    + {12'd0, particle.radius};
			hi_y_s1  <= cfg.bound_bottom - {12'd0, particle.radius};
		end
	end

	// horizontal: left then right edge
	pbi_axis u_axis_x (
		.clk          (clk),
		.ctrl         (ctrl),
		.damping_gain (cfg.damping_gain),
		.pull_gain    (cfg.pull_gain),
		.pos_s1       (pos_x_s1),
		.vel_s1       (vel_x_s1),
		.lo_s1        (lo_x_s1),
		.hi_s1        (hi_x_s1),
		.pos_s5       (pos_x_s5),
		.vel_s5       (vel_x_s5)
	);

	// vertical: top then bottom edge
	pbi_axis u_axis_y (
		.clk          (clk),
		.ctrl         (ctrl),
		.damping_gain (cfg.damping_gain),
		.pull_gain    (cfg.pull_gain),
		.pos_s1       (pos_y_s1),
		.vel_s1       (vel_y_s1),
		.lo_s1        (lo_y_s1),
		.hi_s1        (hi_y_s1),
		.pos_s5       (pos_y_s5),
		.vel_s5       (vel_y_s5)
	);

	// euler step and pixel window, wrapping sums
	assign sum_x = pos_x_s5 + vel_x_s5;
	assign sum_y = pos_y_s5 + vel_y_s5;
	assign pix_x = $signed(sum_x[27:12]);
	assign pix_y = $signed(sum_y[27:12]);

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			nx_s6  <= sum_x;
			ny_s6  <= sum_y;
			nvx_s6 <= vel_x_s5;
			nvy_s6 <= vel_y_s5;
			px_s6  <= sum_x[27:12];
			py_s6  <= sum_y[27:12];
			vis_s6 <= (pix_x >= VIS_MIN) && (pix_x < VIS_MAX_X) &&
				(pix_y >= VIS_MIN) && (pix_y < VIS_MAX_Y);
		end
	end

	assign result.valid      = v_s6;
	assign result.next_pos_x = nx_s6;
	assign result.next_pos_y = ny_s6;
	assign result.next_vel_x = nvx_s6;
	assign result.next_vel_y = nvy_s6;
	assign result.pixel_x    = px_s6;
	assign result.pixel_y    = py_s6;
	assign result.visible    = vis_s6;

	// back-pressure at the input only when the first stage is full
	`ASSERT_IMPLIES(a_ready_low_full, clk, arst_n, !particle.ready, v_s1)
	// a held first stage keeps its item
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, v_s1 && !rdy_s2,
		v_s1 && $stable(pos_x_s1) && $stable(hi_y_s1))
	// visible flag agrees with the pixel fields
	`ASSERT_IMPLIES(a_visible_window, clk, arst_n, result.valid && result.visible,
		($signed(result.pixel_x) >= VIS_MIN) && ($signed(result.pixel_x) < VIS_MAX_X) &&
		($signed(result.pixel_y) >= VIS_MIN) && ($signed(result.pixel_y) < VIS_MAX_Y))
endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
	import pbi_pkg::*;

	// register indexes beyond the map: writes there must leave every register alone
	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [19:0] radius;
	} particle_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic        visible;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_data;

	pbi_in_if  particle_ch ();
	pbi_out_if result_ch ();

	particle_bounds_integrate i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.particle (particle_ch),
		.result   (result_ch)
	);

	// shadow copy of the register file, only touched while the block is idle
	cfg_t        regs;

	particle_t   particle_q[$];  // particles waiting for their transfer
	step_t       step_q[$];      // predicted next states, oldest first

	int          in_count = 0;
	int          out_count = 0;
	int          vis_count = 0;
	int          err_cnt = 0;
	int          n_settings = 1;
	int          offer_mark = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	bit          gaps_on = 1'b1;
	bit          hold_rx = 1'b0;

	// clock, 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------
	// next-state predictor
	// ---------------------------------------------------------------

	function automatic longint wide(input logic [31:0] v);
		return longint'($signed(v));
	endfunction

	// rounded q12 product, low 32 bits of the shifted value
	function automatic logic [31:0] q12_mul(input longint a, input longint b);
		longint p;
		p = a * b + 64'sd2048;
		return p[43:12];
	endfunction

	function automatic step_t step_particle(input particle_t p, input cfg_t c);
		logic [31:0] x, y, vx, vy;
		logic [31:0] lft, top, rgt, bot;
		longint      damp_neg, pull;
		step_t       s;
		x        = p.pos_x;
		y        = p.pos_y;
		vx       = p.vel_x;
		vy       = p.vel_y + GRAVITY;
		// walls move inwards by the radius, wrapping like everything else
		lft      = c.bound_left + {12'd0, p.radius};
		top      = c.bound_top + {12'd0, p.radius};
		rgt      = c.bound_right - {12'd0, p.radius};
		bot      = c.bound_bottom - {12'd0, p.radius};
		damp_neg = -longint'(c.damping_gain);
		pull     = longint'(c.pull_gain);
		// edges in fixed order, each seeing the position the previous one left
		if (wide(x) < wide(lft)) begin
			if (wide(vx) < 0)
				vx = q12_mul(wide(vx), damp_neg);
			x = x + q12_mul(pull, wide(lft - x));
		end
		if (wide(x) > wide(rgt)) begin
			if (wide(vx) > 0)
				vx = q12_mul(wide(vx), damp_neg);
			x = x + q12_mul(pull, wide(rgt - x));
		end
		if (wide(y) < wide(top)) begin
			if (wide(vy) < 0)
				vy = q12_mul(wide(vy), damp_neg);
			y = y + q12_mul(pull, wide(top - y));
		end
		if (wide(y) > wide(bot)) begin
			if (wide(vy) > 0)
				vy = q12_mul(wide(vy), damp_neg);
			y = y + q12_mul(pull, wide(bot - y));
		end
		s.pos_x   = x + vx;
		s.pos_y   = y + vy;
		s.vel_x   = vx;
		s.vel_y   = vy;
		s.pixel_x = s.pos_x[27:12];
		s.pixel_y = s.pos_y[27:12];
		s.visible = ($signed(s.pixel_x) >= VIS_MIN) && ($signed(s.pixel_x) < VIS_MAX_X) &&
			($signed(s.pixel_y) >= VIS_MIN) && ($signed(s.pixel_y) < VIS_MAX_Y);
		return s;
	endfunction

	// ---------------------------------------------------------------
	// particle generation
	// ---------------------------------------------------------------

	function automatic particle_t mk(input logic [31:0] px, input logic [31:0] py,
		input logic [31:0] vx, input logic [31:0] vy, input logic [19:0] r);
		particle_t p;
		p.pos_x  = px;
		p.pos_y  = py;
		p.vel_x  = vx;
		p.vel_y  = vy;
		p.radius = r;
		return p;
	endfunction

	// coordinate clustered round one wall, the other, the middle, or anywhere
	function automatic logic [31:0] near_wall(input logic [31:0] lo, input logic [31:0] hi);
		logic [31:0] jitter;
		jitter = $urandom_range(0, 32'h8_0000) - 32'h4_0000;
		case ($urandom_range(0, 3))
			0: return lo + jitter;
			1: return hi + jitter;
			2: return lo + ((hi - lo) >> 1) + jitter;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_speed();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
	endfunction

	// plausible particles near the current walls, wild_pct percent of them raw bit noise
	function automatic particle_t rand_particle(input int wild_pct);
		logic [19:0] r;
		if ($urandom_range(0, 99) < wild_pct)
			return mk($urandom, $urandom, $urandom, $urandom,
				20'($urandom_range(0, 20'hf_ffff)));
		r = ($urandom_range(0, 15) == 0) ? 20'($urandom_range(0, 20'hf_ffff))
			: 20'($urandom_range(0, 20'h1_0000));
		return mk(near_wall(regs.bound_left, regs.bound_right),
			near_wall(regs.bound_top, regs.bound_bottom), rand_speed(), rand_speed(), r);
	endfunction

	task automatic queue_random(input int n, input int wild_pct);
		repeat (n)
			particle_q.push_back(rand_particle(wild_pct));
	endtask

	// ---------------------------------------------------------------
	// register writes and idle points
	// ---------------------------------------------------------------

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		case (idx)
			CFG_BOUND_LEFT:   regs.bound_left = data;
			CFG_BOUND_TOP:    regs.bound_top = data;
			CFG_BOUND_RIGHT:  regs.bound_right = data;
			CFG_BOUND_BOTTOM: regs.bound_bottom = data;
			CFG_DAMPING_GAIN: regs.damping_gain = data[15:0];
			CFG_PULL_GAIN:    regs.pull_gain = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input logic [31:0] l, input logic [31:0] t, input logic [31:0] r,
		input logic [31:0] b, input logic [15:0] dg, input logic [15:0] pg);
		write_reg(CFG_BOUND_LEFT, l);
		write_reg(CFG_BOUND_TOP, t);
		write_reg(CFG_BOUND_RIGHT, r);
		write_reg(CFG_BOUND_BOTTOM, b);
		write_reg(CFG_DAMPING_GAIN, {16'd0, dg});
		write_reg(CFG_PULL_GAIN, {16'd0, pg});
		n_settings++;
		// new particles go in on a rising edge, clear of the driver at the falling one
		@(posedge clk);
	endtask

	// every item gives one result, so an empty prediction queue means an empty pipe
	task automatic drain();
		do
			@(negedge clk);
		while (particle_q.size() != 0 || step_q.size() != 0);
	endtask

	// ---------------------------------------------------------------
	// particle driver: offers the head of the queue, random gaps between transfers
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
		end else if (particle_ch.valid && in_count == offer_mark) begin
			// offer still open, hold it until the transfer
		end else if (gap_left != 0) begin
			particle_ch.valid <= 1'b0;
			gap_left          <= gap_left - 1;
		end else if (gaps_on && $urandom_range(0, 4) == 0) begin
			particle_ch.valid <= 1'b0;
			gap_left          <= $urandom_range(0, 7);
		end else if (particle_q.size() != 0) begin
			particle_ch.valid  <= 1'b1;
			particle_ch.pos_x  <= particle_q[0].pos_x;
			particle_ch.pos_y  <= particle_q[0].pos_y;
			particle_ch.vel_x  <= particle_q[0].vel_x;
			particle_ch.vel_y  <= particle_q[0].vel_y;
			particle_ch.radius <= particle_q[0].radius;
			offer_mark         <= in_count;
		end else begin
			particle_ch.valid <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// result ready: random stall bursts while gaps are on, plus the long hold-off
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_rx) begin
			result_ch.ready <= 1'b0;
		end else if (!gaps_on) begin
			result_ch.ready <= 1'b1;
		end else if (stall_left != 0) begin
			result_ch.ready <= 1'b0;
			stall_left      <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left      <= $urandom_range(0, 7);
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// long hold-off on the result side while particles keep coming, to back the pipe up
	initial begin
		wait (in_count >= 300);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (80)
			@(posedge clk);
		hold_rx <= 1'b0;
	end

	// ---------------------------------------------------------------
	// particle transfer monitor: predicts the next state at the transfer
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		particle_t got;
		step_t     want;
		if (arst_n && particle_ch.valid && particle_ch.ready) begin
			got  = mk(particle_ch.pos_x, particle_ch.pos_y, particle_ch.vel_x,
				particle_ch.vel_y, particle_ch.radius);
			want = step_particle(got, regs);
			step_q.push_back(want);
			void'(particle_q.pop_front());
			in_count <= in_count + 1;
			if (want.visible)
				vis_count <= vis_count + 1;
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %h, got %h", name, want, got);
			err_cnt++;
		end
	endtask

	// ---------------------------------------------------------------
	// result transfer monitor: compares against the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		step_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			out_count <= out_count + 1;
			if (step_q.size() == 0) begin
				$error("result transfer with no particle outstanding");
				err_cnt++;
			end else begin
				want = step_q.pop_front();
				check_field("next_pos_x", want.pos_x, result_ch.next_pos_x);
				check_field("next_pos_y", want.pos_y, result_ch.next_pos_y);
				check_field("next_vel_x", want.vel_x, result_ch.next_vel_x);
				check_field("next_vel_y", want.vel_y, result_ch.next_vel_y);
				check_field("pixel_x", {16'd0, want.pixel_x}, {16'd0, result_ch.pixel_x});
				check_field("pixel_y", {16'd0, want.pixel_y}, {16'd0, result_ch.pixel_y});
				check_field("visible", {31'd0, want.visible}, {31'd0, result_ch.visible});
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	initial begin
		logic [31:0] edge_l, edge_t;
		logic [31:0] still_y;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_idx            = CFG_BOUND_LEFT;
		cfg_data           = '0;
		particle_ch.valid  = 1'b0;
		particle_ch.pos_x  = '0;
		particle_ch.pos_y  = '0;
		particle_ch.vel_x  = '0;
		particle_ch.vel_y  = '0;
		particle_ch.radius = '0;
		result_ch.ready    = 1'b0;

		regs.bound_left   = RST_BOUND_LEFT;
		regs.bound_top    = RST_BOUND_TOP;
		regs.bound_right  = RST_BOUND_RIGHT;
		regs.bound_bottom = RST_BOUND_BOTTOM;
		regs.damping_gain = RST_DAMPING_GAIN;
		regs.pull_gain    = RST_PULL_GAIN;

		// vertical velocity that gravity brings back to exactly zero
		still_y = 32'd0 - GRAVITY;

		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: one of each wall hit, corners and field extremes
		particle_q.push_back(mk(32'h0008_0000, 32'h0008_0000, 32'h0, 32'h0, 20'h0));
		particle_q.push_back(mk(32'h0003_0000, 32'h0008_0000, 32'hffff_e000, 32'h0, 20'h0_8000));
		particle_q.push_back(mk(32'h0003_0000, 32'h0008_0000, 32'h0000_1000, 32'h0, 20'h0));
		particle_q.push_back(mk(32'h000d_0000, 32'h0008_0000, 32'h0000_3000, 32'h0, 20'h0_4000));
		particle_q.push_back(mk(32'h0008_0000, 32'h0001_0000, 32'h0, 32'hffff_c000, 20'h0));
		particle_q.push_back(mk(32'h0008_0000, 32'h000c_0000, 32'h0, 32'h0000_2000, 20'h0_2000));
		particle_q.push_back(mk(32'h0001_0000, 32'h0001_0000, 32'hffff_f000, 32'hffff_f000,
			20'h0_1000));
		// largest radius turns the shrunk rectangle inside out
		particle_q.push_back(mk(32'h0008_0000, 32'h0008_0000, 32'h0000_0800, 32'hffff_f800,
			20'hf_ffff));
		particle_q.push_back(mk(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			20'h0));
		particle_q.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			20'hf_ffff));
		particle_q.push_back(mk(32'hffff_ffff, 32'h0, 32'h0000_0001, still_y, 20'h0));
		queue_random(200, 20);
		drain();

		// plausible random rectangle and gains; the long hold-off lands in here
		edge_l = $urandom_range(0, 32'h8_0000);
		edge_t = $urandom_range(0, 32'h8_0000);
		set_regs(edge_l, edge_t, edge_l + $urandom_range(32'h4_0000, 32'h20_0000),
			edge_t + $urandom_range(32'h4_0000, 32'h20_0000),
			16'($urandom_range(0, 16'hffff)), 16'($urandom_range(0, 16'hffff)));
		queue_random(260, 15);
		drain();

		// widest rectangle and largest gains; positions outside the pixel window on both axes
		set_regs(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			16'hffff, 16'hffff);
		particle_q.push_back(mk(32'hfff0_0000, 32'h0, 32'h0, still_y, 20'h0));
		particle_q.push_back(mk(32'hffef_0000, 32'h0, 32'h0, still_y, 20'h0));
		particle_q.push_back(mk(32'h010f_0000, 32'h0, 32'h0, still_y, 20'h0));
		particle_q.push_back(mk(32'h0110_0000, 32'h0, 32'h0, still_y, 20'h0));
		particle_q.push_back(mk(32'h0, 32'hfff0_0000, 32'h0, still_y, 20'h0));
		particle_q.push_back(mk(32'h0, 32'hffef_0000, 32'h0, still_y, 20'h0));
		particle_q.push_back(mk(32'h0, 32'h00cf_0000, 32'h0, still_y, 20'h0));
		particle_q.push_back(mk(32'h0, 32'h00d0_0000, 32'h0, still_y, 20'h0));
		// most negative everything against the largest gains
		particle_q.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			20'hf_ffff));
		queue_random(140, 40);
		drain();

		// inside-out rectangle, so both opposite walls act in one step; no idling here
		gaps_on <= 1'b0;
		set_regs(32'h000c_0000, 32'h000b_4000, 32'h0004_0000, 32'h0002_8000,
			16'h1800, 16'h0800);
		particle_q.push_back(mk(32'h0008_0000, 32'h0008_0000, 32'h0000_1000, 32'hffff_f000,
			20'h0));
		particle_q.push_back(mk(32'h0008_0000, 32'h0008_0000, 32'hffff_f000, 32'h0000_1000,
			20'h0_4000));
		particle_q.push_back(mk(32'h0, 32'h0, 32'h0, 32'h0, 20'h0));
		queue_random(140, 15);
		drain();

		// arbitrary walls with both gains at zero
		gaps_on <= 1'b1;
		set_regs($urandom, $urandom, $urandom, $urandom, 16'h0000, 16'h0000);
		queue_random(100, 50);
		drain();

		// closing stretch without idling; writes to unmapped indexes must change nothing
		gaps_on <= 1'b0;
		set_regs(RST_BOUND_LEFT, RST_BOUND_TOP, RST_BOUND_RIGHT, RST_BOUND_BOTTOM,
			16'($urandom_range(0, 16'h2000)), 16'($urandom_range(16'h0800, 16'h1000)));
		write_reg(CFG_SPARE_LO, $urandom);
		write_reg(CFG_SPARE_HI, $urandom);
		@(posedge clk);
		queue_random(180, 10);
		drain();

		// let any stray result past the six pipeline stages show up
		repeat (12)
			@(posedge clk);

		$display("stepped %0d particles under %0d register settings, %0d results checked",
			in_count, n_settings, out_count);
		$display("%0d predicted visible, %0d field mismatches", vis_count, err_cnt);
		if (err_cnt == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#2_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
